// ===== hdl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int KeyW           = 32;
  localparam int ValW           = 32;
  localparam int CfgW           = 5;
  localparam int DefaultEntries = 16;

  localparam logic [CfgW-1:0] CapResetVal = 5'd16;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic signed [ValW-1:0] val_t;

  // read_value on a lookup miss
  localparam val_t MissValue = '1;

  typedef enum logic {
    CmdGet = 1'b0,
    CmdPut = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StUpdate,
    StResult
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic ld_item;
    logic sweep_start;
    logic sweep_scan;
    logic decide;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;
    logic need_update;
  } dp_status_t;

endpackage

// ===== hdl/lkvc_ctrl.sv =====
// Sequencing state machine of the LRU key-value cache.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        if (status_i.sweep_done) state_d = StDecide;
      end
      StDecide: begin
        state_d = status_i.need_update ? StUpdate : StResult;
      end
      StUpdate: begin
        if (status_i.sweep_done) state_d = StResult;
      end
      StResult: begin
        if (!out_valid_q) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item     = 1'b1;
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_scan  = 1'b1;
        end
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        if (status_i.need_update) cmd_o.sweep_start = 1'b1;
      end
      StResult: begin
        if (!out_valid_q) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/lkvc_datapath.sv =====
// Entry memory, valid bits, sweep counter and result registers of the cache.
module lkvc_datapath import lkvc_pkg::*; #(
  parameter int Entries = DefaultEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_cmd_t         cmd_i,
  output dp_status_t      status_o,
  input  logic            cfg_valid_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            cmd_in_i,
  input  key_t            key_i,
  input  val_t            value_i,
  output logic            found_o,
  output val_t            read_value_o,
  output logic            evicted_o
);

  localparam int IdxW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int RankW = IdxW;
  localparam int CntW  = $clog2(Entries + 1);
  localparam int CmpW  = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  typedef struct packed {
    key_t             key;
    val_t             val;
    logic [RankW-1:0] rank;
  } entry_t;

  entry_t mem [Entries];
  entry_t rd_data_q;
  entry_t wr_data;

  logic [CfgW-1:0]    cap_q;
  logic [Entries-1:0] valid_q;
  logic [CntW-1:0]    occ_q;

  // sweep
  logic            run_q, scan_q, rd_vld_q;
  logic [IdxW-1:0] addr_q, rd_idx_q;

  // item
  logic op_q;
  key_t key_q;
  val_t val_q;

  // scan trackers
  logic             hit_q, free_have_q, lru_have_q;
  logic [IdxW-1:0]  hit_idx_q, free_idx_q, lru_idx_q;
  logic [RankW-1:0] hit_rank_q, lru_rank_q;
  val_t             hit_val_q;

  // decision
  logic [IdxW-1:0]  tgt_q;
  logic             ins_q;
  logic             res_found_q, res_evict_q;
  val_t             res_val_q;

  logic [CmpW-1:0] cap_ext, eff_cap;
  logic            evict;
  logic            ent_valid;

  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_q == '0) eff_cap = CmpW'(1);
    else if (cap_ext > CmpW'(Entries)) eff_cap = CmpW'(Entries);
    else eff_cap = cap_ext;
  end

  assign evict     = (op_q == CmdPut) && !hit_q && (CmpW'(occ_q) >= eff_cap);
  assign ent_valid = valid_q[rd_idx_q];

  assign status_o.sweep_done  = rd_vld_q && (rd_idx_q == LastIdx);
  assign status_o.need_update = hit_q || (op_q == CmdPut);

  // write-back word during the update sweep
  always_comb begin
    wr_data = rd_data_q;
    if (rd_idx_q == tgt_q) begin
      wr_data.rank = '0;
      if (ins_q) wr_data.key = key_q;
      if (op_q == CmdPut) wr_data.val = val_q;
    end else if (ins_q || (rd_data_q.rank < hit_rank_q)) begin
      wr_data.rank = rd_data_q.rank + RankW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) rd_data_q <= mem[addr_q];
    if (rd_vld_q && !scan_q) mem[rd_idx_q] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapResetVal;
      valid_q  <= '0;
      occ_q    <= '0;
      run_q    <= 1'b0;
      scan_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      addr_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      rd_vld_q <= run_q;
      rd_idx_q <= addr_q;
      if (cmd_i.sweep_start) begin
        run_q  <= 1'b1;
        scan_q <= cmd_i.sweep_scan;
        addr_q <= '0;
      end else if (run_q) begin
        addr_q <= addr_q + IdxW'(1);
        if (addr_q == LastIdx) run_q <= 1'b0;
      end
      if (cmd_i.decide && !hit_q && (op_q == CmdPut)) begin
        if (evict) begin
          valid_q[lru_idx_q] <= 1'b1;
        end else begin
          valid_q[free_idx_q] <= 1'b1;
          occ_q <= occ_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      op_q  <= cmd_in_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (cmd_i.sweep_start && cmd_i.sweep_scan) begin
      hit_q       <= 1'b0;
      free_have_q <= 1'b0;
      lru_have_q  <= 1'b0;
    end else if (rd_vld_q && scan_q) begin
      if (ent_valid && !hit_q && (rd_data_q.key == key_q)) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= rd_idx_q;
        hit_rank_q <= rd_data_q.rank;
        hit_val_q  <= rd_data_q.val;
      end
      if (!ent_valid && !free_have_q) begin
        free_have_q <= 1'b1;
        free_idx_q  <= rd_idx_q;
      end
      if (ent_valid && (!lru_have_q || (rd_data_q.rank > lru_rank_q))) begin
        lru_have_q <= 1'b1;
        lru_idx_q  <= rd_idx_q;
        lru_rank_q <= rd_data_q.rank;
      end
    end
    if (cmd_i.decide) begin
      ins_q       <= !hit_q;
      res_found_q <= hit_q;
      res_evict_q <= evict;
      if (hit_q) tgt_q <= hit_idx_q;
      else if (evict) tgt_q <= lru_idx_q;
      else tgt_q <= free_idx_q;
      if (op_q == CmdPut) res_val_q <= '0;
      else if (hit_q) res_val_q <= hit_val_q;
      else res_val_q <= MissValue;
    end
    if (cmd_i.load_out) begin
      found_o      <= res_found_q;
      read_value_o <= res_val_q;
      evicted_o    <= res_evict_q;
    end
  end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// One word in gives one word out. Each word is handled on its own: the entry memory has a
// single read port, so a scan pass reads every entry once to find a hit, the first free slot
// and the least recently used entry, and on a hit or a put a second pass rewrites every
// entry's age rank; a lookup miss skips that second pass. The next word is taken once the
// previous result sits in the output register, even while that result still waits to be
// taken. The capacity register may be written at any time the block is idle; it is clamped
// to 1..Entries.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int Entries = DefaultEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cmd_i,
  input  key_t            key_i,
  input  val_t            value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            found_o,
  output val_t            read_value_o,
  output logic            evicted_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  lkvc_datapath #(
    .Entries (Entries)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_in_i     (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o)
  );

endmodule
